[hw/rtl/adrc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// adrc_pkg: shared types, constants and helpers
// Types, micro-program and fixed-point helpers of the nonlinear ADRC block.
// ----------------------------------------------------------------------------
package adrc_pkg;

    // Fixed-point format: signed Q16.16 in 32 bits.
    localparam int DW   = 32;
    localparam int FRAC = 16;
    localparam int MW   = DW + FRAC;

    localparam logic [DW-1:0] QMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] QMIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] ONE_Q = DW'(1) << FRAC;

    // Configuration register indexes.
    localparam logic [2:0] CFG_WC    = 3'd0;
    localparam logic [2:0] CFG_WO    = 3'd1;
    localparam logic [2:0] CFG_B0    = 3'd2;
    localparam logic [2:0] CFG_DL    = 3'd3;
    localparam logic [2:0] CFG_ORDER = 3'd4;
    localparam logic [2:0] CFG_LIM   = 3'd5;
    localparam logic [2:0] CFG_DT    = 3'd6;

    // Operand addresses: temporaries in the scratch memory, then named sources.
    localparam logic [4:0] A_T0   = 5'd0;
    localparam logic [4:0] A_T1   = 5'd1;
    localparam logic [4:0] A_T2   = 5'd2;
    localparam logic [4:0] A_T3   = 5'd3;
    localparam logic [4:0] A_T4   = 5'd4;
    localparam logic [4:0] A_T5   = 5'd5;
    localparam logic [4:0] A_T6   = 5'd6;
    localparam logic [4:0] A_T7   = 5'd7;
    localparam logic [4:0] A_T8   = 5'd8;
    localparam logic [4:0] A_T9   = 5'd9;
    localparam logic [4:0] A_T10  = 5'd10;
    localparam logic [4:0] A_T11  = 5'd11;
    localparam logic [4:0] A_T12  = 5'd12;
    localparam logic [4:0] A_T13  = 5'd13;
    localparam logic [4:0] A_T14  = 5'd14;
    localparam logic [4:0] A_T15  = 5'd15;
    localparam logic [4:0] A_TGT  = 5'd16;
    localparam logic [4:0] A_MEAS = 5'd17;
    localparam logic [4:0] A_WC   = 5'd18;
    localparam logic [4:0] A_WO   = 5'd19;
    localparam logic [4:0] A_B0   = 5'd20;
    localparam logic [4:0] A_DL   = 5'd21;
    localparam logic [4:0] A_LIM  = 5'd22;
    localparam logic [4:0] A_DT   = 5'd23;
    localparam logic [4:0] A_Z1   = 5'd24;
    localparam logic [4:0] A_Z2   = 5'd25;
    localparam logic [4:0] A_Z3   = 5'd26;
    localparam logic [4:0] A_ONE  = 5'd27;
    localparam logic [4:0] A_ZERO = 5'd28;

    // Start of the second order part of the micro-program.
    localparam logic [6:0] PC_ORDER2 = 7'd42;

    typedef enum logic [3:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_SQRT,
        OP_SGN,
        OP_CMPLT,
        OP_CMPZ,
        OP_SEL,
        OP_CLAMP,
        OP_JORD,
        OP_OUT
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_WAIT,
        ST_ZERO
    } state_t;

    typedef struct packed {
        op_t        op;
        logic [4:0] dst;
        logic [4:0] sa;
        logic [4:0] sb;
    } instr_t;

    typedef struct packed {
        logic          start;
        op_t           op;
        logic [DW-1:0] a;
        logic [DW-1:0] b;
    } arith_req_t;

    typedef struct packed {
        logic          done;
        logic [DW-1:0] value;
    } arith_rsp_t;

    // Magnitude of a signed value; the most negative value maps to 2^31.
    function automatic logic [DW-1:0] mag(input logic [DW-1:0] a);
        return a[DW-1] ? (DW'(0) - a) : a;
    endfunction

    // Signed value from sign and wide magnitude, saturated to the range.
    function automatic logic [DW-1:0] from_mag(input logic neg, input logic [MW-1:0] m);
        logic [DW-1:0] r;
        if (!neg)
        begin
            r = (m > MW'(QMAX)) ? QMAX : m[DW-1:0];
        end
        else
        begin
            r = (m > MW'(QMIN)) ? QMIN : (DW'(0) - m[DW-1:0]);
        end
        return r;
    endfunction

    // Saturating sum.
    function automatic logic [DW-1:0] sat_add(input logic [DW-1:0] a, input logic [DW-1:0] b);
        logic [DW:0] s;
        s = {a[DW-1], a} + {b[DW-1], b};
        return (s[DW] != s[DW-1]) ? (s[DW] ? QMIN : QMAX) : s[DW-1:0];
    endfunction

    // Saturating difference.
    function automatic logic [DW-1:0] sat_sub(input logic [DW-1:0] a, input logic [DW-1:0] b);
        logic [DW:0] s;
        s = {a[DW-1], a} - {b[DW-1], b};
        return (s[DW] != s[DW-1]) ? (s[DW] ? QMIN : QMAX) : s[DW-1:0];
    endfunction

    function automatic instr_t mk(input op_t op, input logic [4:0] d,
                                  input logic [4:0] a, input logic [4:0] b);
        instr_t r;
        r.op  = op;
        r.dst = d;
        r.sa  = a;
        r.sb  = b;
        return r;
    endfunction

    // Micro-program. A fal evaluation computes both branches, then selects.
    function automatic instr_t ucode(input logic [6:0] pc);
        instr_t r;
        case (pc)
            // Errors and sigma.
            7'd0:  r = mk(OP_SUB,   A_T0,  A_TGT,  A_Z1);
            7'd1:  r = mk(OP_SUB,   A_T1,  A_Z1,   A_MEAS);
            7'd2:  r = mk(OP_MUL,   A_T2,  A_T1,   A_T1);
            7'd3:  r = mk(OP_ADD,   A_T2,  A_T2,   A_ONE);
            7'd4:  r = mk(OP_DIV,   A_T2,  A_ONE,  A_T2);
            // Linear zone denominators for alpha one half and one quarter.
            7'd5:  r = mk(OP_SQRT,  A_T3,  A_DL,   A_ZERO);
            7'd6:  r = mk(OP_SQRT,  A_T4,  A_T3,   A_ZERO);
            7'd7:  r = mk(OP_MUL,   A_T4,  A_T3,   A_T4);
            // fal of the tracking error, alpha one half.
            7'd8:  r = mk(OP_SQRT,  A_T5,  A_T0,   A_ZERO);
            7'd9:  r = mk(OP_SGN,   A_T5,  A_T0,   A_T5);
            7'd10: r = mk(OP_DIV,   A_T6,  A_T0,   A_T3);
            7'd11: r = mk(OP_CMPLT, A_T0,  A_T0,   A_DL);
            7'd12: r = mk(OP_SEL,   A_T5,  A_T6,   A_T5);
            7'd13: r = mk(OP_CMPZ,  A_T0,  A_DL,   A_ZERO);
            7'd14: r = mk(OP_SEL,   A_T5,  A_T0,   A_T5);
            // fal of the observer error, alpha one half.
            7'd15: r = mk(OP_SQRT,  A_T7,  A_T1,   A_ZERO);
            7'd16: r = mk(OP_SGN,   A_T7,  A_T1,   A_T7);
            7'd17: r = mk(OP_DIV,   A_T6,  A_T1,   A_T3);
            7'd18: r = mk(OP_CMPLT, A_T0,  A_T1,   A_DL);
            7'd19: r = mk(OP_SEL,   A_T7,  A_T6,   A_T7);
            7'd20: r = mk(OP_CMPZ,  A_T0,  A_DL,   A_ZERO);
            7'd21: r = mk(OP_SEL,   A_T7,  A_T1,   A_T7);
            7'd22: r = mk(OP_JORD,  A_T0,  A_ZERO, A_ZERO);
            // First order law.
            7'd23: r = mk(OP_ADD,   A_T8,  A_WO,   A_WO);
            7'd24: r = mk(OP_MUL,   A_T9,  A_WO,   A_WO);
            7'd25: r = mk(OP_MUL,   A_T10, A_WC,   A_T5);
            7'd26: r = mk(OP_MUL,   A_T11, A_T2,   A_Z2);
            7'd27: r = mk(OP_SUB,   A_T10, A_T10,  A_T11);
            7'd28: r = mk(OP_DIV,   A_T10, A_T10,  A_B0);
            7'd29: r = mk(OP_CLAMP, A_T10, A_T10,  A_LIM);
            7'd30: r = mk(OP_MUL,   A_T11, A_T8,   A_T1);
            7'd31: r = mk(OP_SUB,   A_T11, A_Z2,   A_T11);
            7'd32: r = mk(OP_MUL,   A_T12, A_B0,   A_T10);
            7'd33: r = mk(OP_ADD,   A_T11, A_T11,  A_T12);
            7'd34: r = mk(OP_MUL,   A_T11, A_DT,   A_T11);
            7'd35: r = mk(OP_ADD,   A_T11, A_Z1,   A_T11);
            7'd36: r = mk(OP_MUL,   A_T12, A_T9,   A_T7);
            7'd37: r = mk(OP_SUB,   A_T12, A_ZERO, A_T12);
            7'd38: r = mk(OP_MUL,   A_T12, A_DT,   A_T12);
            7'd39: r = mk(OP_ADD,   A_Z2,  A_Z2,   A_T12);
            7'd40: r = mk(OP_ADD,   A_Z1,  A_T11,  A_ZERO);
            7'd41: r = mk(OP_OUT,   A_T0,  A_T10,  A_ZERO);
            // Second order: fal of the observer error, alpha one quarter.
            7'd42: r = mk(OP_SQRT,  A_T13, A_T1,   A_ZERO);
            7'd43: r = mk(OP_SQRT,  A_T13, A_T13,  A_ZERO);
            7'd44: r = mk(OP_SGN,   A_T13, A_T1,   A_T13);
            7'd45: r = mk(OP_DIV,   A_T6,  A_T1,   A_T4);
            7'd46: r = mk(OP_CMPLT, A_T0,  A_T1,   A_DL);
            7'd47: r = mk(OP_SEL,   A_T13, A_T6,   A_T13);
            7'd48: r = mk(OP_CMPZ,  A_T0,  A_DL,   A_ZERO);
            7'd49: r = mk(OP_SEL,   A_T13, A_T1,   A_T13);
            // fal of the negated rate estimate, alpha one quarter.
            7'd50: r = mk(OP_SUB,   A_T8,  A_ZERO, A_Z2);
            7'd51: r = mk(OP_SQRT,  A_T14, A_T8,   A_ZERO);
            7'd52: r = mk(OP_SQRT,  A_T14, A_T14,  A_ZERO);
            7'd53: r = mk(OP_SGN,   A_T14, A_T8,   A_T14);
            7'd54: r = mk(OP_DIV,   A_T6,  A_T8,   A_T4);
            7'd55: r = mk(OP_CMPLT, A_T0,  A_T8,   A_DL);
            7'd56: r = mk(OP_SEL,   A_T14, A_T6,   A_T14);
            7'd57: r = mk(OP_CMPZ,  A_T0,  A_DL,   A_ZERO);
            7'd58: r = mk(OP_SEL,   A_T14, A_T8,   A_T14);
            // Second order law.
            7'd59: r = mk(OP_MUL,   A_T9,  A_WC,   A_WC);
            7'd60: r = mk(OP_ADD,   A_T10, A_WC,   A_WC);
            7'd61: r = mk(OP_MUL,   A_T9,  A_T9,   A_T5);
            7'd62: r = mk(OP_MUL,   A_T10, A_T10,  A_T14);
            7'd63: r = mk(OP_ADD,   A_T9,  A_T9,   A_T10);
            7'd64: r = mk(OP_MUL,   A_T10, A_T2,   A_Z3);
            7'd65: r = mk(OP_SUB,   A_T9,  A_T9,   A_T10);
            7'd66: r = mk(OP_DIV,   A_T9,  A_T9,   A_B0);
            7'd67: r = mk(OP_CLAMP, A_T9,  A_T9,   A_LIM);
            // Observer gains.
            7'd68: r = mk(OP_ADD,   A_T10, A_WO,   A_WO);
            7'd69: r = mk(OP_ADD,   A_T10, A_T10,  A_WO);
            7'd70: r = mk(OP_MUL,   A_T11, A_T10,  A_WO);
            7'd71: r = mk(OP_MUL,   A_T12, A_WO,   A_WO);
            7'd72: r = mk(OP_MUL,   A_T12, A_T12,  A_WO);
            // New position estimate.
            7'd73: r = mk(OP_MUL,   A_T10, A_T10,  A_T1);
            7'd74: r = mk(OP_SUB,   A_T10, A_Z2,   A_T10);
            7'd75: r = mk(OP_MUL,   A_T10, A_DT,   A_T10);
            7'd76: r = mk(OP_ADD,   A_T10, A_Z1,   A_T10);
            // New rate estimate.
            7'd77: r = mk(OP_MUL,   A_T11, A_T11,  A_T7);
            7'd78: r = mk(OP_SUB,   A_T11, A_Z3,   A_T11);
            7'd79: r = mk(OP_MUL,   A_T15, A_B0,   A_T9);
            7'd80: r = mk(OP_ADD,   A_T11, A_T11,  A_T15);
            7'd81: r = mk(OP_MUL,   A_T11, A_DT,   A_T11);
            7'd82: r = mk(OP_ADD,   A_T11, A_Z2,   A_T11);
            // New disturbance estimate, then commit.
            7'd83: r = mk(OP_MUL,   A_T12, A_T12,  A_T13);
            7'd84: r = mk(OP_SUB,   A_T12, A_ZERO, A_T12);
            7'd85: r = mk(OP_MUL,   A_T12, A_DT,   A_T12);
            7'd86: r = mk(OP_ADD,   A_Z3,  A_Z3,   A_T12);
            7'd87: r = mk(OP_ADD,   A_Z2,  A_T11,  A_ZERO);
            7'd88: r = mk(OP_ADD,   A_Z1,  A_T10,  A_ZERO);
            7'd89: r = mk(OP_OUT,   A_T0,  A_T9,   A_ZERO);
            default: r = mk(OP_OUT, A_T0,  A_ZERO, A_ZERO);
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/adrc_arith.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// adrc_arith: serial multiply, divide and square root
// One bit (or one two-bit digit for the root) per cycle, result saturated.
// ----------------------------------------------------------------------------
module adrc_arith
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  adrc_pkg::arith_req_t   req,
    output adrc_pkg::arith_rsp_t   rsp
);
    import adrc_pkg::*;

    logic          busy_reg;
    logic          fin_reg;
    logic [5:0]    cnt_reg;
    op_t           op_reg;
    logic          neg_reg;
    logic [MW-1:0] x_reg;
    logic [DW-1:0] y_reg;
    logic [DW:0]   r_reg;
    logic [MW-1:0] q_reg;

    logic [MW-1:0] x_next;
    logic [DW:0]   r_next;
    logic [MW-1:0] q_next;
    logic [DW:0]   sum;
    logic [DW:0]   trial;
    logic [DW:0]   part;
    logic          ge;
    logic [DW-1:0] ma;
    logic [DW-1:0] mb;
    logic [MW-1:0] res_mag;

    assign ma = mag(req.a);
    assign mb = mag(req.b);

    // One iteration of the running operation.
    always_comb
    begin
        sum    = {1'b0, r_reg[DW-1:0]} + (x_reg[0] ? {1'b0, y_reg} : '0);
        part   = '0;
        trial  = '0;
        ge     = 1'b0;
        x_next = x_reg;
        r_next = r_reg;
        q_next = q_reg;
        case (op_reg)
            OP_MUL:
            begin
                r_next = {1'b0, sum[DW:1]};
                q_next = {sum[0], q_reg[MW-1:1]};
                x_next = x_reg >> 1;
            end
            OP_DIV:
            begin
                part   = {r_reg[DW-1:0], x_reg[MW-1]};
                trial  = {1'b0, y_reg};
                ge     = part >= trial;
                r_next = ge ? (part - trial) : part;
                q_next = {q_reg[MW-2:0], ge};
                x_next = x_reg << 1;
            end
            OP_SQRT:
            begin
                part   = {r_reg[DW-2:0], x_reg[MW-1:MW-2]};
                trial  = {q_reg[DW-2:0], 2'b01};
                ge     = part >= trial;
                r_next = ge ? (part - trial) : part;
                q_next = {q_reg[MW-2:0], ge};
                x_next = x_reg << 2;
            end
            default:
            begin
                x_next = x_reg;
            end
        endcase
    end

    // Sequencing of the serial unit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= OP_MUL;
        end
        else
        begin
            fin_reg <= 1'b0;
            if (req.start)
            begin
                op_reg <= req.op;
                if (req.op == OP_DIV && mb == '0)
                begin
                    fin_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                    case (req.op)
                        OP_MUL:  cnt_reg <= 6'(DW - 1);
                        OP_DIV:  cnt_reg <= 6'(MW - 1);
                        default: cnt_reg <= 6'(MW / 2 - 1);
                    endcase
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
        end
    end

    // Operand and partial result registers.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            r_reg <= '0;
            case (req.op)
                OP_MUL:
                begin
                    x_reg   <= {{FRAC{1'b0}}, mb};
                    y_reg   <= ma;
                    q_reg   <= '0;
                    neg_reg <= req.a[DW-1] ^ req.b[DW-1];
                end
                OP_DIV:
                begin
                    x_reg   <= {ma, {FRAC{1'b0}}};
                    y_reg   <= mb;
                    neg_reg <= req.a[DW-1] ^ req.b[DW-1];
                    // A zero divisor saturates toward the numerator's sign.
                    if (mb == '0)
                    begin
                        q_reg   <= (ma == '0) ? '0 : '1;
                        neg_reg <= req.a[DW-1];
                    end
                    else
                    begin
                        q_reg <= '0;
                    end
                end
                default:
                begin
                    x_reg   <= {ma, {FRAC{1'b0}}};
                    y_reg   <= mb;
                    q_reg   <= '0;
                    neg_reg <= 1'b0;
                end
            endcase
        end
        else if (busy_reg)
        begin
            x_reg <= x_next;
            r_reg <= r_next;
            q_reg <= q_next;
        end
    end

    // The product keeps its upper bits after the fraction shift.
    assign res_mag   = (op_reg == OP_MUL) ? {r_reg[DW-1:0], q_reg[MW-1:DW]} : q_reg;
    assign rsp.done  = fin_reg;
    assign rsp.value = from_mag(neg_reg, res_mag);

endmodule
`default_nettype wire

[hw/rtl/adrc_nonlinear_eso_controller.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// adrc_nonlinear_eso_controller: nonlinear ADRC with fal observer
// Q16.16 controller driven by a micro-program over a serial arithmetic unit.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_stall) carries one item: operation,
//   target_value and measured_value. An update item (operation 0) gives one
//   drive_value item on the output channel (out_valid/out_stall); an
//   observer reset item (operation 1) loads the position estimate with the
//   measurement, clears the others and gives no result.
//   Configuration is written over cfg_valid/cfg_ready with cfg_index and
//   cfg_data, only while the block is idle; the user must keep to this, as
//   the block itself does not enforce it. cfg_ready is always high.
//   Each micro-instruction passes through ST_READ and ST_EXEC; a multiply,
//   divide or square root then waits in ST_WAIT for the serial unit, which
//   finishes a divide by zero early. An unused order gives drive 0 through
//   ST_ZERO without running the program. One item is worked on at a time;
//   in_stall is high while an item is at work.
//   The result sits in an output register; a new item is accepted while it
//   waits, and the next result waits for it to be taken.
//   Reset restores the default registers and clears the three estimates.
// ----------------------------------------------------------------------------
module adrc_nonlinear_eso_controller
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        operation,
    input  wire logic [31:0] target_value,
    input  wire logic [31:0] measured_value,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      drive_value,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import adrc_pkg::*;

    state_t        state_reg;
    state_t        state_next;
    logic [6:0]    pc_reg;
    logic [6:0]    pc_next;
    logic          flag_reg;
    logic          flag_next;

    logic [30:0]   wc_reg;
    logic [30:0]   wo_reg;
    logic [30:0]   b0_reg;
    logic [30:0]   dl_reg;
    logic [1:0]    order_reg;
    logic [30:0]   lim_reg;
    logic [30:0]   dt_reg;

    logic [DW-1:0] tgt_reg;
    logic [DW-1:0] meas_reg;
    logic [DW-1:0] z1_reg;
    logic [DW-1:0] z2_reg;
    logic [DW-1:0] z3_reg;

    logic [DW-1:0] scratch [16];
    logic [DW-1:0] rda_reg;
    logic [DW-1:0] rdb_reg;
    logic [DW-1:0] spa_reg;
    logic [DW-1:0] spb_reg;

    logic          out_valid_reg;
    logic [DW-1:0] drive_reg;

    instr_t        instr;
    logic [DW-1:0] opa;
    logic [DW-1:0] opb;
    logic [DW-1:0] alu_res;
    logic          in_acc;
    logic          out_free;
    logic          wr_en;
    logic [DW-1:0] wr_data;
    logic          out_load;
    logic [DW-1:0] out_data;
    arith_req_t    req;
    arith_rsp_t    rsp;

    // Named operand sources outside the scratch memory.
    function automatic logic [DW-1:0] special(input logic [4:0] addr);
        logic [DW-1:0] v;
        case (addr)
            A_TGT:   v = tgt_reg;
            A_MEAS:  v = meas_reg;
            A_WC:    v = {1'b0, wc_reg};
            A_WO:    v = {1'b0, wo_reg};
            A_B0:    v = {1'b0, b0_reg};
            A_DL:    v = {1'b0, dl_reg};
            A_LIM:   v = {1'b0, lim_reg};
            A_DT:    v = {1'b0, dt_reg};
            A_Z1:    v = z1_reg;
            A_Z2:    v = z2_reg;
            A_Z3:    v = z3_reg;
            A_ONE:   v = ONE_Q;
            default: v = '0;
        endcase
        return v;
    endfunction

    assign instr     = ucode(pc_reg);
    assign opa       = instr.sa[4] ? spa_reg : rda_reg;
    assign opb       = instr.sb[4] ? spb_reg : rdb_reg;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;
    assign out_valid   = out_valid_reg;
    assign drive_value = drive_reg;

    // Combinational operations.
    always_comb
    begin
        case (instr.op)
            OP_ADD:  alu_res = sat_add(opa, opb);
            OP_SUB:  alu_res = sat_sub(opa, opb);
            OP_SGN:  alu_res = opa[DW-1] ? sat_sub('0, opb) : opb;
            OP_SEL:  alu_res = flag_reg ? opa : opb;
            OP_CLAMP:
            begin
                if (opb == '0)
                    alu_res = opa;
                else if ($signed(opa) > $signed(opb))
                    alu_res = opb;
                else if ($signed(opa) < $signed(DW'(0) - opb))
                    alu_res = DW'(0) - opb;
                else
                    alu_res = opa;
            end
            default: alu_res = opa;
        endcase
    end

    // Next state and sequencing outputs.
    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        flag_next  = flag_reg;
        wr_en      = 1'b0;
        wr_data    = alu_res;
        out_load   = 1'b0;
        out_data   = '0;
        req.start  = 1'b0;
        req.op     = instr.op;
        req.a      = opa;
        req.b      = opb;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && !operation)
                begin
                    pc_next = '0;
                    if (order_reg == 2'd1 || order_reg == 2'd2)
                        state_next = ST_READ;
                    else
                        state_next = ST_ZERO;
                end
            end
            ST_READ:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                case (instr.op)
                    OP_MUL, OP_DIV, OP_SQRT:
                    begin
                        req.start  = 1'b1;
                        state_next = ST_WAIT;
                    end
                    OP_CMPLT:
                    begin
                        flag_next  = mag(opa) < mag(opb);
                        pc_next    = pc_reg + 7'd1;
                        state_next = ST_READ;
                    end
                    OP_CMPZ:
                    begin
                        flag_next  = (opa == '0);
                        pc_next    = pc_reg + 7'd1;
                        state_next = ST_READ;
                    end
                    OP_JORD:
                    begin
                        pc_next    = (order_reg == 2'd2) ? PC_ORDER2 : pc_reg + 7'd1;
                        state_next = ST_READ;
                    end
                    OP_OUT:
                    begin
                        if (out_free)
                        begin
                            out_load   = 1'b1;
                            out_data   = opa;
                            state_next = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        wr_en      = 1'b1;
                        pc_next    = pc_reg + 7'd1;
                        state_next = ST_READ;
                    end
                endcase
            end
            ST_WAIT:
            begin
                if (rsp.done)
                begin
                    wr_en      = 1'b1;
                    wr_data    = rsp.value;
                    pc_next    = pc_reg + 7'd1;
                    state_next = ST_READ;
                end
            end
            ST_ZERO:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pc_reg    <= '0;
            flag_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            flag_reg  <= flag_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wc_reg    <= 31'd655360;
            wo_reg    <= 31'd983040;
            b0_reg    <= 31'd655360;
            dl_reg    <= 31'd65536;
            order_reg <= 2'd1;
            lim_reg   <= 31'd65536;
            dt_reg    <= 31'd164;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_WC:    wc_reg    <= cfg_data[30:0];
                CFG_WO:    wo_reg    <= cfg_data[30:0];
                CFG_B0:    b0_reg    <= cfg_data[30:0];
                CFG_DL:    dl_reg    <= cfg_data[30:0];
                CFG_ORDER: order_reg <= cfg_data[1:0];
                CFG_LIM:   lim_reg   <= cfg_data[30:0];
                CFG_DT:    dt_reg    <= cfg_data[30:0];
                default:   dt_reg    <= dt_reg;
            endcase
        end
    end

    // Observer estimates: loaded by a reset item or written by the program.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            z1_reg <= '0;
            z2_reg <= '0;
            z3_reg <= '0;
        end
        else if (in_acc && operation)
        begin
            z1_reg <= measured_value;
            z2_reg <= '0;
            z3_reg <= '0;
        end
        else if (wr_en)
        begin
            if (instr.dst == A_Z1)
                z1_reg <= wr_data;
            if (instr.dst == A_Z2)
                z2_reg <= wr_data;
            if (instr.dst == A_Z3)
                z3_reg <= wr_data;
        end
    end

    // Captured input item.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            tgt_reg  <= target_value;
            meas_reg <= measured_value;
        end
    end

    // Scratch memory with two registered read ports, and the named sources.
    always_ff @(posedge clk)
    begin
        if (wr_en && !instr.dst[4])
            scratch[instr.dst[3:0]] <= wr_data;
        rda_reg <= scratch[instr.sa[3:0]];
        rdb_reg <= scratch[instr.sb[3:0]];
        spa_reg <= special(instr.sa);
        spb_reg <= special(instr.sb);
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            drive_reg <= out_data;
    end

    // Serial multiply, divide and square root.
    adrc_arith u_arith
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

endmodule
`default_nettype wire

[sim/tb_adrc_nonlinear_eso_controller.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_adrc_nonlinear_eso_controller: self-checking testbench
// Drives update and observer reset items through the controller under several
// register settings. Each drive value is checked against a Q16.16 predictor of
// the fal observer law that lives in this bench.
// ----------------------------------------------------------------------------
module tb_adrc_nonlinear_eso_controller;
    import adrc_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int IDLE_LIMIT  = 60000;
    localparam int SETTLE      = 40;
    localparam int RANDOM_ITEMS = 1500;
    localparam logic OPC_UPDATE = 1'b0;
    localparam logic OPC_RESET  = 1'b1;
    localparam int S_MAX = 32'h7fffffff;
    localparam int S_MIN = 32'h80000000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        operation;
    logic [31:0] target_value;
    logic [31:0] measured_value;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] drive_value;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    adrc_nonlinear_eso_controller DUT
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .target_value   (target_value),
        .measured_value (measured_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .drive_value    (drive_value),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // Predictor copy of the registers and observer estimates.
    int wc_r, wo_r, b0_r, dl_r, lim_r, dt_r;
    int order_r;
    int z_pos, z_rate, z_dist;

    // Expected drive values, oldest first.
    int drive_q[$];
    int errors;
    int burst_left;
    int idle_cycles;

    initial
    begin
        clk = 1'b0;
    end

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------
    // Saturating Q16.16 arithmetic.
    // ------------------------------------------------------------------
    function automatic int sat(input longint x);
        if (x > longint'(S_MAX))
        begin
            return S_MAX;
        end
        if (x < longint'(S_MIN))
        begin
            return S_MIN;
        end
        return int'(x);
    endfunction

    function automatic int qadd(input int a, input int b);
        return sat(longint'(a) + longint'(b));
    endfunction

    function automatic int qsub(input int a, input int b);
        return sat(longint'(a) - longint'(b));
    endfunction

    function automatic longint unsigned magn(input int a);
        return a < 0 ? longint'(-longint'(a)) : longint'(a);
    endfunction

    function automatic int signed_of(input bit neg, input longint unsigned m);
        if (!neg)
        begin
            return (m > 64'h7fffffff) ? S_MAX : int'(m);
        end
        if (m > 64'h80000000)
        begin
            return S_MIN;
        end
        return int'(-longint'(m));
    endfunction

    function automatic int qmul(input int a, input int b);
        return signed_of((a < 0) != (b < 0), (magn(a) * magn(b)) >> 16);
    endfunction

    function automatic int qdiv(input int a, input int b);
        if (b == 0)
        begin
            return a > 0 ? S_MAX : (a < 0 ? S_MIN : 0);
        end
        return signed_of((a < 0) != (b < 0), (magn(a) << 16) / magn(b));
    endfunction

    // Floor root of a value scaled by 2^16.
    function automatic longint unsigned qroot(input longint unsigned m);
        longint unsigned n, res, bitv;
        n = m << 16;
        res = 0;
        bitv = 64'h4000000000000000;
        while (bitv > n)
        begin
            bitv = bitv >> 2;
        end
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Nonlinear gain: linear inside the zone, a root of the magnitude outside.
    function automatic int fal_q(input int x, input bit quarter, input int d);
        longint unsigned mx, r2;
        int dv;
        if (d == 0)
        begin
            return x;
        end
        mx = magn(x);
        if (mx < magn(d))
        begin
            r2 = qroot(magn(d));
            dv = signed_of(1'b0, r2);
            if (quarter)
            begin
                dv = qmul(dv, signed_of(1'b0, qroot(r2)));
            end
            return qdiv(x, dv);
        end
        mx = qroot(mx);
        if (quarter)
        begin
            mx = qroot(mx);
        end
        return signed_of(x < 0, mx);
    endfunction

    function automatic int clamp_drive(input int u);
        if (lim_r != 0)
        begin
            if (u > lim_r)
            begin
                return lim_r;
            end
            if (u < -lim_r)
            begin
                return -lim_r;
            end
        end
        return u;
    endfunction

    // Advances the predicted estimates; returns the drive of an update item.
    function automatic int predict_drive(input int tgt, input int meas);
        int e1, e, sigma, u, fe, fe1, b1, b2, b3, kp, kd, n1, n2, n3;
        u = 0;
        e1 = qsub(tgt, z_pos);
        e = qsub(z_pos, meas);
        sigma = qdiv(32'h10000, qadd(qmul(e, e), 32'h10000));
        if (order_r == 1)
        begin
            b1 = qadd(wo_r, wo_r);
            b2 = qmul(wo_r, wo_r);
            fe = fal_q(e, 1'b0, dl_r);
            u = qdiv(qsub(qmul(wc_r, fal_q(e1, 1'b0, dl_r)), qmul(sigma, z_rate)), b0_r);
            u = clamp_drive(u);
            n1 = qadd(z_pos, qmul(dt_r,
                 qadd(qsub(z_rate, qmul(b1, e)), qmul(b0_r, u))));
            z_rate = qadd(z_rate, qmul(dt_r, qsub(0, qmul(b2, fe))));
            z_pos = n1;
        end
        else if (order_r == 2)
        begin
            kp = qmul(wc_r, wc_r);
            kd = qadd(wc_r, wc_r);
            b1 = qadd(qadd(wo_r, wo_r), wo_r);
            b2 = qmul(b1, wo_r);
            b3 = qmul(qmul(wo_r, wo_r), wo_r);
            fe = fal_q(e, 1'b0, dl_r);
            fe1 = fal_q(e, 1'b1, dl_r);
            u = qdiv(qsub(qadd(qmul(kp, fal_q(e1, 1'b0, dl_r)),
                              qmul(kd, fal_q(qsub(0, z_rate), 1'b1, dl_r))),
                         qmul(sigma, z_dist)), b0_r);
            u = clamp_drive(u);
            n1 = qadd(z_pos, qmul(dt_r, qsub(z_rate, qmul(b1, e))));
            n2 = qadd(z_rate, qmul(dt_r,
                 qadd(qsub(z_dist, qmul(b2, fe)), qmul(b0_r, u))));
            n3 = qadd(z_dist, qmul(dt_r, qsub(0, qmul(b3, fe1))));
            z_pos = n1;
            z_rate = n2;
            z_dist = n3;
        end
        return u;
    endfunction

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // ------------------------------------------------------------------
    // Item sender: bursts of random length separated by random gaps.
    // ------------------------------------------------------------------
    task automatic send_item(input logic op, input int tgt, input int meas,
                             input bit typed, input int typed_drive);
        int gap, u;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid       <= 1'b1;
        operation      <= op;
        target_value   <= tgt;
        measured_value <= meas;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        burst_left--;
        if (op == OPC_RESET)
        begin
            z_pos = meas;
            z_rate = 0;
            z_dist = 0;
        end
        else
        begin
            u = predict_drive(tgt, meas);
            drive_q.push_back(typed ? typed_drive : u);
        end
    endtask

    // Register write; the sender holds off until the block is idle.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        in_valid <= 1'b0;
        burst_left = 0;
        while (drive_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        case (idx)
            CFG_WC:    wc_r = val & 32'h7fffffff;
            CFG_WO:    wo_r = val & 32'h7fffffff;
            CFG_B0:    b0_r = val & 32'h7fffffff;
            CFG_DL:    dl_r = val & 32'h7fffffff;
            CFG_ORDER: order_r = val & 32'h3;
            CFG_LIM:   lim_r = val & 32'h7fffffff;
            CFG_DT:    dt_r = val & 32'h7fffffff;
            default:   ;
        endcase
    endtask

    function automatic logic [31:0] pick_reg(input bit nonzero);
        case ($urandom_range(0, 7))
            0:       return nonzero ? 32'd1 : 32'd0;
            1:       return 32'h7fffffff;
            2:       return $urandom();
            3:       return 32'd1;
            default: return ($urandom_range(0, 40) << 16) + $urandom_range(1, 65535);
        endcase
    endfunction

    function automatic int pick_value();
        case ($urandom_range(0, 5))
            0:       return $urandom();
            1:       return S_MAX;
            2:       return S_MIN;
            default: return int'($urandom_range(0, 8 << 16)) - (4 << 16);
        endcase
    endfunction

    // Directed rows: register writes and items, some with a typed drive value.
    typedef struct {
        bit          is_cfg;
        logic [2:0]  idx;
        logic [31:0] val;
        logic        op;
        int          tgt;
        int          meas;
        bit          typed;
        int          drive;
    } row_t;

    row_t rows[] = '{
        '{0, CFG_WC, 0, OPC_UPDATE, 0, 0, 0, 0},
        '{0, CFG_WC, 0, OPC_RESET, 0, 0, 0, 0},
        '{0, CFG_WC, 0, OPC_UPDATE, S_MAX, 0, 1, 32'h10000},
        '{0, CFG_WC, 0, OPC_RESET, 0, 0, 0, 0},
        '{0, CFG_WC, 0, OPC_UPDATE, S_MIN, 0, 1, -32'sh10000},
        '{0, CFG_WC, 0, OPC_UPDATE, 32'h8000, 32'h4000, 0, 0},
        '{0, CFG_WC, 0, OPC_RESET, 0, S_MIN, 0, 0},
        '{0, CFG_WC, 0, OPC_UPDATE, S_MAX, S_MAX, 0, 0},
        '{0, CFG_WC, 0, OPC_RESET, 0, S_MAX, 0, 0},
        '{0, CFG_WC, 0, OPC_UPDATE, S_MIN, S_MIN, 0, 0},
        '{1, CFG_DL, 0, OPC_UPDATE, 0, 0, 0, 0},
        '{0, CFG_WC, 0, OPC_UPDATE, 32'h20000, -32'sh8000, 0, 0},
        '{1, CFG_ORDER, 2, OPC_UPDATE, 0, 0, 0, 0},
        '{0, CFG_WC, 0, OPC_UPDATE, 32'h18000, 32'h100, 0, 0},
        '{1, CFG_DL, 32'h10000, OPC_UPDATE, 0, 0, 0, 0},
        '{0, CFG_WC, 0, OPC_UPDATE, S_MIN, S_MAX, 0, 0},
        '{0, CFG_WC, 0, OPC_UPDATE, 32'h4000, -32'sh4000, 0, 0},
        '{1, CFG_ORDER, 0, OPC_UPDATE, 0, 0, 0, 0},
        '{0, CFG_WC, 0, OPC_UPDATE, S_MAX, S_MIN, 1, 0},
        '{1, CFG_ORDER, 3, OPC_UPDATE, 0, 0, 0, 0},
        '{0, CFG_WC, 0, OPC_UPDATE, 32'h12345, 32'h54321, 1, 0},
        '{1, CFG_ORDER, 2, OPC_UPDATE, 0, 0, 0, 0},
        '{1, CFG_LIM, 0, OPC_UPDATE, 0, 0, 0, 0},
        '{1, CFG_WO, 32'hffffffff, OPC_UPDATE, 0, 0, 0, 0},
        '{1, CFG_DT, 32'h7fffffff, OPC_UPDATE, 0, 0, 0, 0},
        '{1, CFG_B0, 1, OPC_UPDATE, 0, 0, 0, 0},
        '{1, CFG_WC, 32'h7fffffff, OPC_UPDATE, 0, 0, 0, 0},
        '{0, CFG_WC, 0, OPC_UPDATE, S_MAX, S_MIN, 0, 0},
        '{0, CFG_WC, 0, OPC_UPDATE, S_MIN, S_MAX, 0, 0},
        '{1, CFG_ORDER, 1, OPC_UPDATE, 0, 0, 0, 0},
        '{1, CFG_WC, 0, OPC_UPDATE, 0, 0, 0, 0},
        '{0, CFG_WC, 0, OPC_UPDATE, S_MAX, 32'h1, 0, 0}
    };

    // ------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------
    initial
    begin
        int sent, items;
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = 1'b0;
        target_value = 0;
        measured_value = 0;
        cfg_valid = 1'b0;
        cfg_index = CFG_WC;
        cfg_data = 0;
        errors = 0;
        burst_left = 0;
        wc_r = 655360;
        wo_r = 983040;
        b0_r = 655360;
        dl_r = 65536;
        order_r = 1;
        lim_r = 65536;
        dt_r = 164;
        z_pos = 0;
        z_rate = 0;
        z_dist = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].is_cfg)
            begin
                write_reg(rows[i].idx, rows[i].val);
            end
            else
            begin
                send_item(rows[i].op, rows[i].tgt, rows[i].meas, rows[i].typed,
                          rows[i].drive);
            end
        end

        // Random phases, each under a fresh register setting.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            write_reg(CFG_WC, pick_reg(0));
            write_reg(CFG_WO, pick_reg(0));
            write_reg(CFG_B0, pick_reg(1));
            write_reg(CFG_DL, pick_reg(0));
            write_reg(CFG_LIM, ($urandom_range(0, 3) == 0) ? pick_reg(0)
                                                             : ($urandom_range(1, 8) << 16));
            write_reg(CFG_DT, ($urandom_range(0, 3) == 0) ? pick_reg(1)
                                                            : $urandom_range(1, 2000));
            write_reg(CFG_ORDER, ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) * 3)
                                                               : $urandom_range(1, 2));
            items = $urandom_range(40, 120);
            repeat (items)
            begin
                send_item(($urandom_range(0, 9) == 0) ? OPC_RESET : OPC_UPDATE,
                          pick_value(), pick_value(), 0, 0);
                sent++;
            end
        end

        in_valid <= 1'b0;
        while (drive_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
        if (errors == 0 && drive_q.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver stall pattern: free runs, random stalls and long holds.
    // ------------------------------------------------------------------
    int stall_mode;
    int stall_run;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_mode <= 0;
            stall_run  <= 0;
        end
        else
        begin
            if (stall_run == 0)
            begin
                stall_mode <= $urandom_range(0, 2);
                stall_run  <= $urandom_range(1, 300);
            end
            else
            begin
                stall_run <= stall_run - 1;
            end
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= $urandom_range(0, 1);
                default: out_stall <= 1'b1;
            endcase
        end
    end

    // Drive value check against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (drive_q.size() == 0)
            begin
                report("unexpected drive_value", int'(drive_value), 0);
            end
            else if (int'(drive_value) != drive_q[0])
            begin
                report("drive_value", int'(drive_value), drive_q.pop_front());
            end
            else
            begin
                void'(drive_q.pop_front());
            end
        end
    end

    // Watchdog on cycles in which no handshake completes.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
`default_nettype wire
